### design/ccd_pkg.sv
// ---------------------------------------------------------------------------
// Circling/cruise detector package
// Mode codes, field widths and fixed constants shared by the detector files.
// ---------------------------------------------------------------------------
package ccd_pkg;

	localparam logic [2:0] MODE_UNKNOWN   = 3'd0;
	localparam logic [2:0] MODE_CRUISE    = 3'd1;
	localparam logic [2:0] MODE_WAITCLIMB = 3'd2;
	localparam logic [2:0] MODE_CLIMB     = 3'd3;
	localparam logic [2:0] MODE_WAITCRUISE = 3'd4;

	localparam logic [1:0] KIND_PARAGLIDER = 2'd1;

	localparam logic [1:0] REG_AIRCRAFT_KIND = 2'd0;
	localparam logic [1:0] REG_TRIGGER_EN    = 2'd1;

	localparam int IN_W  = 56;
	localparam int OUT_W = 112;

	localparam logic [14:0] FULL_TURN  = 15'd23040;
	localparam logic [11:0] RATE_LIMIT = 12'd3200;
	localparam logic [11:0] MIN_RATE   = 12'd256;

endpackage

### design/circling_cruise_detector_core.sv
// ---------------------------------------------------------------------------
// Circling/cruise detector core
// Turn rate, bearing prediction, rate filter, flight mode machine and
// percent-circling figure for one GPS fix per item, on one shared divider.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   s_axis_tdata (fix)
//  m_axis    out        m_axis_tvalid / m_axis_tready   m_axis_tdata (result)
//  cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A full fix runs three passes of the shared one-bit-per-cycle restoring
// divider (22, 40 and 48 steps) plus sequencing. With a time step of two
// seconds or more the 40-step pass is left out. A skipped fix uses the
// divider only for the percent division, and not at all while fewer than
// two fixes have been counted.
// Reset is asynchronous; the block is ready right after it.
// A finished result waits in the output register while the next item is taken.
module circling_cruise_detector_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// fix_time, track_bearing, is_flying, force_cruise, force_circling
	input  logic [ccd_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// updated, flight_mode, circling_flag, climb_started, cruise_started,
	// phase_start_time, raw_turn_rate, filtered_rate, turning_left,
	// predicted_bearing, circling_percent
	output logic [ccd_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [1:0]             cfg_data
);
	import ccd_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_R     = 4'd3;
	localparam logic [3:0] S_P2    = 4'd4;
	localparam logic [3:0] S_P3    = 4'd5;
	localparam logic [3:0] S_Q     = 4'd6;
	localparam logic [3:0] S_M     = 4'd7;
	localparam logic [3:0] S_F     = 4'd8;
	localparam logic [3:0] S_FR    = 4'd9;
	localparam logic [3:0] S_MODE  = 4'd10;
	localparam logic [3:0] S_PCT   = 4'd11;
	localparam logic [3:0] S_PCT2  = 4'd12;
	localparam logic [3:0] S_PR    = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;
	localparam logic [3:0] S_M2    = 4'd15;

	logic [3:0]  state_q, ret_q;
	logic [1:0]  kind_q;
	logic        trig_en_q;

	logic [31:0] t_q;
	logic [14:0] b_q;
	logic        fly_q, fcr_q, fci_q;

	logic [2:0]  mode_q;
	logic [31:0] prev_time_q;
	logic [14:0] prev_bearing_q;
	logic signed [12:0] prev_rate_q;
	logic [31:0] start_q;
	logic        circ_q;
	logic [31:0] circle_cnt_q, cruise_cnt_q;

	logic [47:0] div_num_q;
	logic [33:0] div_den_q, div_rem_q;
	logic [5:0]  div_cnt_q;

	logic        neg_q;
	logic signed [22:0] r_q;
	logic [39:0] p1_q;
	logic signed [41:0] num_q;
	logic signed [26:0] v_q;
	logic [11:0] q45_q;
	logic [15:0] fmag_q;
	logic signed [12:0] f_q;
	logic [46:0] prod_q;

	logic        res_upd_q, res_cs_q, res_crs_q, res_left_q;
	logic [31:0] res_ps_q;
	logic [11:0] res_rate_q;
	logic [14:0] res_pred_q, pct_q;
	logic        m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	logic [31:0] dt;
	logic signed [16:0] diff0, diff_w;
	logic [13:0] absd;
	logic [17:0] dt300;
	logic [18:0] den1000;
	logic [34:0] rem_sh;
	logic        div_ge;
	logic [34:0] rem_sub;
	logic signed [23:0] rl;
	logic signed [37:0] t2;
	logic signed [41:0] p1_s;
	logic [41:0] absn;
	logic [21:0] q22;
	logic signed [22:0] r_new;
	logic signed [26:0] v_new;
	logic [25:0] absv;
	logic [16:0] yv;
	logic [34:0] yprod;
	logic [16:0] r45;
	logic [14:0] modv;
	logic [14:0] pred_new;
	logic signed [12:0] x_cl, f_new;
	logic signed [16:0] fsum;
	logic [15:0] abssum;
	logic [31:0] fprod;
	logic [11:0] rate;
	logic [32:0] total;
	logic        fcr_e, fci_e, is_pg, is_car;
	logic [11:0] th_cruise, th_climb;
	logic [32:0] dwell;

	logic [2:0]  nm;
	logic [31:0] nst, nps;
	logic        ncirc, ncs, ncrs, fin;
	logic signed [32:0] el;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign dt      = t_q - prev_time_q;
	assign diff0   = $signed({2'b00, b_q}) - $signed({2'b00, prev_bearing_q});
	always_comb begin
		diff_w = diff0;
		if (diff0 > 17'sd11520) begin
			diff_w = diff0 - 17'sd23040;
		end else if (diff0 < -17'sd11520) begin
			diff_w = diff0 + 17'sd23040;
		end
	end
	assign absd    = diff_w[16] ? 14'(-diff_w) : diff_w[13:0];
	assign dt300   = 18'(dt[8:0]) * 18'd300;
	assign den1000 = 19'(dt[8:0]) * 19'd1000;

	assign rem_sh  = {div_rem_q, div_num_q[47]};
	assign div_ge  = rem_sh >= {1'b0, div_den_q};
	assign rem_sub = rem_sh - {1'b0, div_den_q};

	assign q22   = div_num_q[21:0];
	assign r_new = neg_q ? -$signed({1'b0, q22}) : $signed({1'b0, q22});
	assign rl    = 24'(r_q) - 24'(prev_rate_q);
	assign t2    = 38'(rl) * 38'sd11520;
	assign p1_s  = $signed({2'b00, p1_q});
	assign absn  = num_q[41] ? 42'(-num_q) : 42'(num_q);
	assign v_new = $signed({12'b0, b_q}) + (neg_q ? -$signed({1'b0, div_num_q[25:0]})
		: $signed({1'b0, div_num_q[25:0]}));
	assign absv  = v_q[26] ? 26'(-v_q) : v_q[25:0];

	// A full turn is 512 times 45, so the bearing wraps by a reciprocal
	// division of the upper bits by 45 while the low nine bits pass through.
	assign yv    = absv[25:9];
	assign yprod = 35'(yv) * 35'd186414;
	assign r45   = yv - 17'(q45_q) * 17'd45;
	assign modv  = {r45[5:0], absv[8:0]};
	assign pred_new = (v_q[26] && modv != 15'd0) ? FULL_TURN - modv : modv;

	always_comb begin
		if (r_q > 23'sd3200) begin
			x_cl = 13'sd3200;
		end else if (r_q < -23'sd3200) begin
			x_cl = -13'sd3200;
		end else begin
			x_cl = r_q[12:0];
		end
		if (mode_q == MODE_CLIMB || mode_q == MODE_WAITCRUISE) begin
			fsum = 17'(x_cl) + 17'(prev_rate_q) * 17'sd9;
		end else begin
			fsum = 17'(x_cl) * 17'sd7 + 17'(prev_rate_q) * 17'sd3;
		end
	end
	assign abssum = fsum[16] ? 16'(-fsum) : fsum[15:0];
	assign fprod  = 32'(fmag_q) * 32'd52429;
	assign f_new  = neg_q ? -$signed({1'b0, fprod[30:19]}) : $signed({1'b0, fprod[30:19]});
	assign rate   = f_q[12] ? 12'(-f_q) : f_q[11:0];
	assign total  = {1'b0, circle_cnt_q} + {1'b0, cruise_cnt_q};

	assign fcr_e     = trig_en_q & fcr_q;
	assign fci_e     = trig_en_q & ~fcr_q & fci_q;
	assign is_pg     = (kind_q == KIND_PARAGLIDER);
	assign is_car    = kind_q[1];
	assign th_cruise = is_pg ? 12'd320 : 12'd256;
	assign th_climb  = is_pg ? 12'd640 : 12'd256;
	assign dwell     = is_pg ? 33'd3840 : 33'd2304;

	always_comb begin
		nm = mode_q; nst = start_q; ncirc = circ_q; ncs = 1'b0; ncrs = 1'b0;
		nps = 32'd0; fin = 1'b0; el = 33'sd0;
		if (nm == MODE_CRUISE) begin
			if (fci_e || rate >= th_cruise) begin
				nst = t_q;
				nm  = MODE_WAITCLIMB;
			end
			if (!fci_e) fin = 1'b1;
		end
		if (!fin && nm == MODE_WAITCLIMB) begin
			el = $signed({1'b0, t_q}) - $signed({1'b0, nst});
			if (fcr_e || nst == 32'd0) begin
				nm = MODE_CRUISE;
			end else if (fci_e || rate >= th_cruise) begin
				if ((!is_car && el > 33'sd3840) || fci_e) begin
					nm = MODE_CLIMB; ncirc = 1'b1; ncs = 1'b1; nps = nst;
				end
			end else begin
				nm = MODE_CRUISE;
			end
			fin = 1'b1;
		end
		if (!fin && nm == MODE_CLIMB) begin
			if (rate < th_climb || fcr_e) begin
				nst = t_q;
				nm  = MODE_WAITCRUISE;
			end
			if (!fcr_e) fin = 1'b1;
		end
		if (!fin && nm == MODE_WAITCRUISE) begin
			el = $signed({1'b0, t_q}) - $signed({1'b0, nst});
			if (fci_e) begin
				nm = MODE_CLIMB;
			end else if (fcr_e || rate < th_climb) begin
				if (fcr_e || el > $signed(dwell)) begin
					if (nst == 32'd0) nst = t_q;
					ncirc = 1'b0; ncrs = 1'b1; nps = nst; nm = MODE_CRUISE;
				end
			end else begin
				nm = MODE_CLIMB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			kind_q <= 2'd0;
			trig_en_q <= 1'b0;
			mode_q <= MODE_CRUISE;
			prev_time_q <= 32'd0;
			prev_bearing_q <= 15'd0;
			prev_rate_q <= 13'sd0;
			start_q <= 32'd0;
			circ_q <= 1'b0;
			circle_cnt_q <= 32'd0;
			cruise_cnt_q <= 32'd0;
			div_cnt_q <= 6'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_AIRCRAFT_KIND) kind_q <= cfg_data;
				else if (cfg_index == REG_TRIGGER_EN) trig_en_q <= cfg_data[0];
			end
			if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						t_q   <= s_axis_tdata[31:0];
						b_q   <= s_axis_tdata[46:32];
						fly_q <= s_axis_tdata[47];
						fcr_q <= s_axis_tdata[48];
						fci_q <= s_axis_tdata[49];
						state_q <= S_START;
					end
				end
				S_START: begin
					res_cs_q <= 1'b0;
					res_left_q <= 1'b0; res_ps_q <= 32'd0; res_rate_q <= 12'd0;
					res_pred_q <= 15'd0; r_q <= 23'sd0;
					if (!fly_q) begin
						res_upd_q <= 1'b0; res_crs_q <= 1'b0;
						mode_q <= MODE_UNKNOWN;
						state_q <= S_PCT;
					end else if (mode_q == MODE_UNKNOWN || t_q < prev_time_q) begin
						prev_bearing_q <= 15'd0; prev_time_q <= 32'd0;
						prev_rate_q <= 13'sd0; start_q <= 32'd0;
						mode_q <= MODE_CRUISE; circ_q <= 1'b0;
						res_upd_q <= 1'b0; res_crs_q <= 1'b1;
						state_q <= S_PCT;
					end else if (dt == 32'd0) begin
						res_upd_q <= 1'b0; res_crs_q <= 1'b0;
						state_q <= S_PCT;
					end else begin
						res_upd_q <= 1'b1; res_crs_q <= 1'b0;
						neg_q <= diff_w[16];
						div_num_q <= {2'b00, absd, 8'd0, 24'd0} << 2;
						div_den_q <= {2'b00, dt};
						div_rem_q <= 34'd0;
						div_cnt_q <= 6'd22;
						ret_q <= S_R;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_rem_q <= div_ge ? rem_sub[33:0] : rem_sh[33:0];
					div_num_q <= {div_num_q[46:0], div_ge};
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == 6'd1) state_q <= ret_q;
				end
				S_R: begin
					r_q  <= r_new;
					p1_q <= q22 * 40'(dt300);
					if (dt < 32'd512) begin
						state_q <= S_P2;
					end else begin
						v_q <= $signed({12'b0, b_q});
						state_q <= S_M;
					end
				end
				S_P2: begin
					num_q <= (r_q[22] ? -p1_s : p1_s) + 42'(t2);
					state_q <= S_P3;
				end
				S_P3: begin
					neg_q <= num_q[41];
					div_num_q <= {absn[39:0] + {21'd0, den1000[18:1]}, 8'd0};
					div_den_q <= 34'(den1000);
					div_rem_q <= 34'd0;
					div_cnt_q <= 6'd40;
					ret_q <= S_Q;
					state_q <= S_DIV;
				end
				S_Q: begin
					v_q <= v_new;
					state_q <= S_M;
				end
				S_M: begin
					q45_q <= yprod[34:23];
					state_q <= S_M2;
				end
				S_M2: begin
					res_pred_q <= pred_new;
					state_q <= S_F;
				end
				S_F: begin
					neg_q <= fsum[16];
					fmag_q <= abssum + 16'd5;
					state_q <= S_FR;
				end
				S_FR: begin
					f_q <= f_new;
					prev_rate_q <= f_new;
					prev_time_q <= t_q;
					prev_bearing_q <= b_q;
					state_q <= S_MODE;
				end
				S_MODE: begin
					if (circ_q && rate > MIN_RATE) begin
						if (circle_cnt_q != 32'hFFFF_FFFF) circle_cnt_q <= circle_cnt_q + 32'd1;
					end else begin
						if (cruise_cnt_q != 32'hFFFF_FFFF) cruise_cnt_q <= cruise_cnt_q + 32'd1;
					end
					res_rate_q <= rate;
					res_left_q <= f_q[12];
					mode_q <= nm; start_q <= nst; circ_q <= ncirc;
					res_cs_q <= ncs; res_crs_q <= ncrs; res_ps_q <= nps;
					state_q <= S_PCT;
				end
				S_PCT: begin
					prod_q <= 47'(circle_cnt_q) * 47'd25600;
					if (total <= 33'd1) begin
						pct_q <= 15'd0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PCT2;
					end
				end
				S_PCT2: begin
					div_num_q <= {1'b0, prod_q};
					div_den_q <= {1'b0, total};
					div_rem_q <= 34'd0;
					div_cnt_q <= 6'd48;
					ret_q <= S_PR;
					state_q <= S_DIV;
				end
				S_PR: begin
					pct_q <= div_num_q[14:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_data_q <= {7'd0, pct_q, res_pred_q, res_left_q, res_rate_q,
							r_q, res_ps_q, res_crs_q, res_cs_q, circ_q, mode_q, res_upd_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/ccd_checker.sv
// ---------------------------------------------------------------------------
// Circling/cruise detector port checker
// Watches the ports of the detector core for handshake and result sanity.
// ---------------------------------------------------------------------------
module ccd_port_props (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [ccd_pkg::OUT_W-1:0] m_axis_tdata
);
	import ccd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[73:62] <= RATE_LIMIT)
		else $error("filtered rate above limit");

	a_climb: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[3:1] == MODE_CLIMB && m_axis_tdata[4])
		else $error("climb start without climb mode");

	a_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[3:1] == MODE_CRUISE && !m_axis_tdata[4])
		else $error("cruise start without cruise mode");

endmodule

bind circling_cruise_detector_core ccd_port_props u_ccd_port_props (.*);

### sim/ccd_checker.sv
// ---------------------------------------------------------------------------
// Circling/cruise detector checker
// Watches the fix, result and register channels, predicts each result from
// its own copy of the detector state and compares the fields in order.
// ---------------------------------------------------------------------------
module ccd_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [111:0] m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [1:0]   cfg_data,
	output int           errors,
	output int           pending
);
	import ccd_pkg::*;

	logic [1:0]   kind;
	logic         trig_en;
	logic [2:0]   mode;
	logic [31:0]  last_time;
	logic [14:0]  last_bearing;
	int           last_rate;
	logic [31:0]  phase_time;
	logic         circling;
	logic [31:0]  circle_fixes;
	logic [31:0]  cruise_fixes;
	logic [104:0] expected_results[$];

	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		mag = num < 0 ? -num : num;
		mag = (mag + den / 2) / den;
		return num < 0 ? -mag : mag;
	endfunction

	function automatic logic [14:0] percent_circling();
		longint unsigned total;
		total = longint'(circle_fixes) + longint'(cruise_fixes);
		if (total <= 1)
			return '0;
		return 15'((longint'(circle_fixes) * 25600) / total);
	endfunction

	// Advances the detector state by one fix and returns the packed result.
	function automatic logic [104:0] detect_fix(input logic [55:0] d);
		logic [31:0] t, dt, mag, pst;
		logic [14:0] b;
		logic fly, fcr, fci, pg, car, done, left, upd, climb_go, cruise_go;
		int th_cruise, th_climb, diff, r, x, f, rate;
		longint dwell, num, pred;
		t = d[31:0];
		b = d[46:32];
		fly = d[47];
		fcr = 1'b0;
		fci = 1'b0;
		pg = (kind == KIND_PARAGLIDER);
		car = (kind >= 2);
		th_cruise = pg ? 320 : 256;
		th_climb = pg ? 640 : 256;
		dwell = pg ? 3840 : 2304;
		upd = 0; climb_go = 0; cruise_go = 0; pst = 0;
		r = 0; rate = 0; left = 0; pred = 0;
		done = 0;
		if (!fly) begin
			mode = MODE_UNKNOWN;
			done = 1;
		end else if (mode == MODE_UNKNOWN || t < last_time) begin
			last_bearing = 0; last_time = 0; last_rate = 0; phase_time = 0;
			mode = MODE_CRUISE;
			circling = 0;
			cruise_go = 1;
			done = 1;
		end else if (t == last_time) begin
			done = 1;
		end
		if (!done) begin
			dt = t - last_time;
			diff = int'(b) - int'(last_bearing);
			while (diff > 11520) diff -= 23040;
			while (diff < -11520) diff += 23040;
			mag = (32'(diff < 0 ? -diff : diff) * 32'd256) / dt;
			r = diff < 0 ? -int'(mag) : int'(mag);
			if (dt < 512) begin
				num = 300 * longint'(r) * longint'(dt) + 11520 * (longint'(r) - last_rate);
				pred = longint'(b) + round_div(num, 1000 * longint'(dt));
			end else
				pred = longint'(b);
			pred = pred % 23040;
			if (pred < 0) pred += 23040;
			x = r > 3200 ? 3200 : (r < -3200 ? -3200 : r);
			if (mode == MODE_CLIMB || mode == MODE_WAITCRUISE)
				f = int'(round_div(longint'(x) + 9 * longint'(last_rate), 10));
			else
				f = int'(round_div(7 * longint'(x) + 3 * longint'(last_rate), 10));
			last_rate = f;
			last_time = t;
			last_bearing = b;
			left = f < 0;
			rate = left ? -f : f;
			if (circling && rate > 256) begin
				if (circle_fixes != '1) circle_fixes++;
			end else begin
				if (cruise_fixes != '1) cruise_fixes++;
			end
			if (trig_en) begin
				fcr = d[48];
				fci = !fcr && d[49];
			end
			upd = 1;
			if (mode == MODE_CRUISE) begin
				if (fci || rate >= th_cruise) begin
					phase_time = t;
					mode = MODE_WAITCLIMB;
				end
				if (!fci) done = 1;
			end
			if (!done && mode == MODE_WAITCLIMB) begin
				if (fcr || phase_time == 0)
					mode = MODE_CRUISE;
				else if (fci || rate >= th_cruise) begin
					if ((!car && longint'(t) - longint'(phase_time) > 3840) || fci) begin
						mode = MODE_CLIMB;
						circling = 1;
						climb_go = 1;
						pst = phase_time;
					end
				end else
					mode = MODE_CRUISE;
				done = 1;
			end
			if (!done && mode == MODE_CLIMB) begin
				if (rate < th_climb || fcr) begin
					phase_time = t;
					mode = MODE_WAITCRUISE;
				end
				if (!fcr) done = 1;
			end
			if (!done && mode == MODE_WAITCRUISE) begin
				if (fci)
					mode = MODE_CLIMB;
				else if (fcr || rate < th_climb) begin
					if (fcr || longint'(t) - longint'(phase_time) > dwell) begin
						if (phase_time == 0) phase_time = t;
						circling = 0;
						cruise_go = 1;
						pst = phase_time;
						mode = MODE_CRUISE;
					end
				end else
					mode = MODE_CLIMB;
			end
		end
		return {percent_circling(), 15'(pred), left, 12'(rate), 23'(r), pst,
			cruise_go, climb_go, circling, mode, upd};
	endfunction

	function automatic int field_ok(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [104:0] e, a;
		int ok;
		if (!arst_n) begin
			kind <= '0; trig_en <= 0; mode <= MODE_CRUISE;
			last_time <= '0; last_bearing <= '0; last_rate <= 0; phase_time <= '0;
			circling <= 0; circle_fixes <= '0; cruise_fixes <= '0;
			expected_results.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_AIRCRAFT_KIND) kind = cfg_data;
				else if (cfg_index == REG_TRIGGER_EN) trig_en = cfg_data[0];
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(detect_fix(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				a = m_axis_tdata[104:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h", $time, a);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					ok = field_ok("updated", e[0], a[0])
						& field_ok("flight_mode", e[3:1], a[3:1])
						& field_ok("circling_flag", e[4], a[4])
						& field_ok("climb_started", e[5], a[5])
						& field_ok("cruise_started", e[6], a[6])
						& field_ok("phase_start_time", e[38:7], a[38:7])
						& field_ok("raw_turn_rate", e[61:39], a[61:39])
						& field_ok("filtered_rate", e[73:62], a[73:62])
						& field_ok("turning_left", e[74], a[74])
						& field_ok("predicted_bearing", e[89:75], a[89:75])
						& field_ok("circling_percent", e[104:90], a[104:90]);
					if (!ok) errors <= errors + 1;
				end
			end
		end
	end

	assign pending = expected_results.size();

endmodule

### sim/tb_circling_cruise_detector_core.sv
// ---------------------------------------------------------------------------
// Circling/cruise detector testbench
// Drives directed and random GPS fixes under several register settings with
// random gaps and stalls on both streams; the checker judges every result.
// ---------------------------------------------------------------------------
module tb_circling_cruise_detector_core;
	import ccd_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [1:0]   cfg_data;
	int           errors;
	int           pending;
	int           quiet_cycles;
	logic         hold_request;

	logic [31:0]  fix_clock;
	longint       heading;
	int           turn_rate;
	int           segment_left;

	circling_cruise_detector_core u_dut (.*);

	ccd_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Nothing accepted on any channel for this long means the block hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 0;
				repeat (400) @(negedge clk);
			end else begin
				n = $urandom_range(0, 4);
				if (n > 0) begin
					m_axis_tready <= 0;
					repeat (n) @(negedge clk);
				end
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_fix(input logic [31:0] t, input logic [14:0] b, input logic fly,
			input logic fcr, input logic fci);
		int n;
		n = $urandom_range(0, 4);
		if (n > 0) begin
			s_axis_tvalid <= 0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'b0, fci, fcr, fly, b, t};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic settle();
		s_axis_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// Next fix of a flight made of straight legs and sustained turns, with
	// landings, clock jumps, repeated times and stray bearings mixed in.
	task automatic random_fix();
		int pick, dt;
		logic fcr, fci;
		if (segment_left == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				turn_rate = $urandom_range(900, 3000) * ($urandom_range(0, 1) ? 1 : -1);
			else if (pick < 8)
				turn_rate = $urandom_range(0, 400) - 200;
			else
				turn_rate = $urandom_range(0, 12000) - 6000;
			segment_left = $urandom_range(5, 40);
		end
		segment_left--;
		fcr = 0;
		fci = 0;
		if ($urandom_range(0, 99) < 6) begin
			fcr = $urandom_range(0, 1);
			fci = $urandom_range(0, 1);
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_fix(fix_clock, 15'($urandom), 0, fcr, fci);
		end else if (pick < 5) begin
			fix_clock = fix_clock - $urandom_range(1, 5000);
			send_fix(fix_clock, 15'(heading), 1, fcr, fci);
		end else if (pick < 7) begin
			send_fix(fix_clock, 15'(heading), 1, fcr, fci);
		end else if (pick < 9) begin
			fix_clock = fix_clock + $urandom_range(1, 600);
			send_fix(fix_clock, 15'($urandom), 1, fcr, fci);
		end else begin
			dt = ($urandom_range(0, 9) < 6) ? 256 : $urandom_range(1, 700);
			fix_clock = fix_clock + dt;
			heading = (heading + longint'(turn_rate) * dt / 256) % 23040;
			if (heading < 0) heading += 23040;
			send_fix(fix_clock, 15'(heading), 1, fcr, fci);
		end
	endtask

	initial begin
		logic [1:0] kinds[6];
		logic       enables[6];
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_request = 0;
		quiet_cycles = 0;
		heading = 0;
		turn_rate = 0;
		segment_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		kinds = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0};
		enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

		write_reg(REG_TRIGGER_EN, 1);
		send_fix(32'd0, 15'd0, 0, 0, 0);
		send_fix(32'd0, 15'd0, 1, 0, 0);
		send_fix(32'd0, 15'd100, 1, 0, 0);
		send_fix(32'd1, 15'd23039, 1, 0, 0);
		send_fix(32'd2, 15'd0, 1, 0, 0);
		send_fix(32'd258, 15'd11520, 1, 0, 0);
		send_fix(32'd514, 15'd32767, 1, 0, 0);
		send_fix(32'd600, 15'd100, 1, 0, 1);
		send_fix(32'd700, 15'd200, 1, 1, 1);
		send_fix(32'd800, 15'd300, 1, 0, 1);
		send_fix(32'd900, 15'd400, 1, 0, 1);
		send_fix(32'd1000, 15'd500, 1, 1, 0);
		send_fix(32'd1000, 15'd500, 1, 0, 0);
		send_fix(32'd999, 15'd500, 1, 0, 0);
		send_fix(32'hFFFF_FF00, 15'd7000, 1, 0, 0);
		send_fix(32'hFFFF_FFFF, 15'd20000, 1, 0, 0);
		send_fix(32'h0000_0010, 15'd0, 1, 0, 0);
		send_fix(32'h0000_0020, 15'd0, 1, 0, 0);
		settle();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_AIRCRAFT_KIND, kinds[p]);
			write_reg(REG_TRIGGER_EN, enables[p]);
			fix_clock = (p == 3) ? 32'hFFFF_0000 : (p == 4 ? 32'h7FFF_FF00 : $urandom);
			for (int i = 0; i < 315; i++) begin
				if (p == 1 && i == 50) hold_request <= 1;
				if (p == 1 && i == 52) hold_request <= 0;
				random_fix();
			end
			settle();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
design/ccd_pkg.sv
design/circling_cruise_detector_core.sv
design/ccd_checker.sv
sim/ccd_checker.sv
sim/tb_circling_cruise_detector_core.sv
